// ===== hdl/pbd_pkg.sv =====
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types, constants and helper functions of the page boundary detector.
// ----------------------------------------------------------------------------
package pbd_pkg;

  localparam int OFFSET_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam int OUT_OFS_W   = 32;
  localparam int PAGE_W      = 20;
  localparam int LINES_W     = 16;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 3;
  localparam int TDATA_W     = ((OUT_OFS_W + 1 + 7) / 8) * 8;
  localparam int TUSER_W     = 3;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_9 = 8'h39;

  localparam logic [LINES_W-1:0] LINES_MAX        = '1;
  localparam logic [LINES_W-1:0] TROFF_LINE_START = LINES_W'(1);
  localparam logic [LINES_W-1:0] TROFF_MARK_LEN   = LINES_W'(2);
  localparam logic [PAGE_W-1:0]  PAGE_MAX         = '1;

  localparam logic [LINES_W-1:0] LINES_PER_PAGE_RST = LINES_W'(66);
  localparam logic [PAGE_W-1:0]  RANGE_A_FIRST_RST  = PAGE_W'(1);
  localparam logic [PAGE_W-1:0]  RANGE_A_LAST_RST   = PAGE_W'(99999);
  localparam logic [PAGE_W-1:0]  RANGE_B_FIRST_RST  = PAGE_W'(1);
  localparam logic [PAGE_W-1:0]  RANGE_B_LAST_RST   = PAGE_W'(0);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LINES_PER_PAGE = 3'd0,
    REG_TROFF_MODE     = 3'd1,
    REG_END_FORMFEED   = 3'd2,
    REG_SELECT_ALL     = 3'd3,
    REG_RANGE_A_FIRST  = 3'd4,
    REG_RANGE_A_LAST   = 3'd5,
    REG_RANGE_B_FIRST  = 3'd6,
    REG_RANGE_B_LAST   = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [LINES_W-1:0] lines_per_page;
    logic               troff_mode;
    logic               end_formfeed;
    logic               select_all;
    logic [PAGE_W-1:0]  range_a_first;
    logic [PAGE_W-1:0]  range_a_last;
    logic [PAGE_W-1:0]  range_b_first;
    logic [PAGE_W-1:0]  range_b_last;
  } pbd_cfg_t;

  // Which results one input byte causes, and how the closing one looks.
  typedef struct packed {
    logic end_ff;
    logic end_bnd;
    logic end_v;
    logic mid_v;
    logic start_v;
  } pbd_slots_t;

  localparam int SLOTS_W = $bits(pbd_slots_t);

  function automatic logic [PAGE_W-1:0] page_inc(input logic [PAGE_W-1:0] pn);
    page_inc = (pn == PAGE_MAX) ? pn : pn + PAGE_W'(1);
  endfunction

  function automatic logic page_in_set(input pbd_cfg_t cfg, input logic [PAGE_W-1:0] pn);
    page_in_set = cfg.select_all
               || (pn >= cfg.range_a_first && pn <= cfg.range_a_last)
               || (pn >= cfg.range_b_first && pn <= cfg.range_b_last);
  endfunction

endpackage

// ===== hdl/pbd_front.sv =====
// ----------------------------------------------------------------------------
// pbd_front
// Accepts stream bytes, classifies them and keeps the per-stream counters,
// and hands one record per byte that causes results to the queue.
// ----------------------------------------------------------------------------
module pbd_front #(
  parameter int OFFSET_BITS = pbd_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pbd_pkg::pbd_cfg_t               cfg,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // data_byte
  input  logic                            s_tlast,   // end_of_input
  input  logic                            queue_full,
  output logic                            push,
  output pbd_pkg::pbd_slots_t             rec_slots,
  output logic [OFFSET_BITS-1:0]          rec_mid_ofs,
  output logic [OFFSET_BITS-1:0]          rec_end_ofs,
  output logic [pbd_pkg::PAGE_W-1:0]      rec_page
);
  import pbd_pkg::*;

  logic [OFFSET_BITS-1:0] byte_count;
  logic [OFFSET_BITS-1:0] line_start;
  logic [LINES_W-1:0]     line_count;
  logic                   page_full;
  logic [PAGE_W-1:0]      page_number;
  logic                   started;

  logic [OFFSET_BITS-1:0] line_start_next;
  logic [LINES_W-1:0]     line_count_next;
  logic                   page_full_next;
  logic [PAGE_W-1:0]      page_number_next;

  logic                   accept;
  logic                   plain;
  logic [OFFSET_BITS-1:0] bc_inc;
  logic [OFFSET_BITS-1:0] bc_inc2;
  logic [LINES_W-1:0]     lc_up;
  logic [1:0]             boundaries;
  logic [PAGE_W:0]        page_sum;

  assign s_tready = !queue_full;
  assign accept   = s_tvalid && s_tready;
  assign plain    = !cfg.troff_mode;
  assign bc_inc   = (byte_count == '1) ? byte_count : byte_count + OFFSET_BITS'(1);
  assign bc_inc2  = (bc_inc == '1) ? bc_inc : bc_inc + OFFSET_BITS'(1);
  assign lc_up    = (line_count == LINES_MAX) ? line_count : line_count + LINES_W'(1);

  always_comb begin
    line_start_next    = line_start;
    line_count_next    = line_count;
    page_full_next     = page_full;
    rec_slots          = '0;
    rec_slots.start_v  = !started && plain;
    rec_mid_ofs        = bc_inc;
    if (plain) begin
      if (s_tdata == CH_NL) begin
        if (lc_up >= cfg.lines_per_page) begin
          rec_slots.mid_v = 1'b1;
          line_count_next = '0;
          page_full_next  = 1'b1;
        end else begin
          line_count_next = lc_up;
        end
      end else if (s_tdata == CH_FF) begin
        if (!page_full) begin
          rec_slots.mid_v = 1'b1;
          line_count_next = '0;
        end
        page_full_next = 1'b0;
      end else begin
        page_full_next = 1'b0;
      end
    end else begin
      if (s_tdata == CH_NL) begin
        rec_slots.mid_v = line_count > TROFF_MARK_LEN;
        rec_mid_ofs     = line_start;
        line_start_next = bc_inc;
        line_count_next = TROFF_LINE_START;
      end else if (s_tdata == CH_P) begin
        line_count_next = (line_count == TROFF_LINE_START) ? TROFF_MARK_LEN : '0;
      end else if (s_tdata >= CH_DIG_0 && s_tdata <= CH_DIG_9) begin
        line_count_next = (line_count >= TROFF_MARK_LEN) ? lc_up : '0;
      end else begin
        line_count_next = '0;
      end
    end
    rec_slots.end_v   = s_tlast;
    rec_slots.end_ff  = plain && cfg.end_formfeed && (line_count_next != '0);
    rec_slots.end_bnd = !plain || !page_full_next;
  end

  assign rec_end_ofs = rec_slots.end_ff ? bc_inc2 : bc_inc;
  assign rec_page    = page_number;
  assign push        = accept && (rec_slots.start_v || rec_slots.mid_v || rec_slots.end_v);

  assign boundaries = 2'(rec_slots.start_v) + 2'(rec_slots.mid_v);
  assign page_sum   = {1'b0, page_number} + (PAGE_W+1)'(boundaries);
  assign page_number_next = (page_sum > {1'b0, PAGE_MAX}) ? PAGE_MAX : page_sum[PAGE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      line_start  <= '0;
      line_count  <= '0;
      page_full   <= 1'b0;
      page_number <= '0;
      started     <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        byte_count  <= '0;
        line_start  <= '0;
        line_count  <= '0;
        page_full   <= 1'b0;
        page_number <= '0;
        started     <= 1'b0;
      end else begin
        byte_count  <= bc_inc;
        line_start  <= line_start_next;
        line_count  <= line_count_next;
        page_full   <= page_full_next;
        page_number <= page_number_next;
        started     <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/pbd_queue.sv =====
// ----------------------------------------------------------------------------
// pbd_queue
// Short first-in first-out queue of result records between front and back.
// ----------------------------------------------------------------------------
module pbd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pbd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);
  import pbd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/pbd_back.sv =====
// ----------------------------------------------------------------------------
// pbd_back
// Takes records from the queue and sends their results one beat at a time,
// numbering pages and testing them against the selection ranges.
// ----------------------------------------------------------------------------
module pbd_back #(
  parameter int OFFSET_BITS = pbd_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pbd_pkg::pbd_cfg_t               cfg,
  input  logic                            head_valid,
  input  pbd_pkg::pbd_slots_t             head_slots,
  input  logic [OFFSET_BITS-1:0]          head_mid_ofs,
  input  logic [OFFSET_BITS-1:0]          head_end_ofs,
  input  logic [pbd_pkg::PAGE_W-1:0]      head_page,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // bits 31:0 page_offset, bit 32 page_selected, zero above
  output logic [pbd_pkg::TDATA_W-1:0]     m_tdata,
  // bit 0 is_boundary, bit 1 end_result, bit 2 formfeed_appended
  output logic [pbd_pkg::TUSER_W-1:0]     m_tuser,
  output logic                            m_tlast    // last_of_run
);
  import pbd_pkg::*;

  logic [OUT_OFS_W-1:0] out_ofs;
  logic                 out_sel;
  logic                 out_bnd;
  logic                 out_end;
  logic                 out_ff;
  logic                 out_last;
  logic [2:0]           sent;
  logic [PAGE_W-1:0]    page_run;

  logic                   can_load;
  logic                   fire;
  logic [2:0]             pending;
  logic [2:0]             pick;
  logic [2:0]             after;
  logic                   pick_bnd;
  logic [PAGE_W-1:0]      page_cur;
  logic [PAGE_W-1:0]      page_up;
  logic [PAGE_W-1:0]      page_use;
  logic [OFFSET_BITS-1:0] pick_ofs;

  assign can_load = !m_tvalid || m_tready;
  assign fire     = can_load && head_valid;
  assign pending  = {head_slots.end_v, head_slots.mid_v, head_slots.start_v} & ~sent;

  always_comb begin
    pick = 3'b000;
    if (pending[0]) begin
      pick = 3'b001;
    end else if (pending[1]) begin
      pick = 3'b010;
    end else if (pending[2]) begin
      pick = 3'b100;
    end
  end

  assign after    = pending & ~pick;
  assign pick_bnd = pick[2] ? head_slots.end_bnd : 1'b1;
  assign page_cur = (sent == 3'b000) ? head_page : page_run;
  assign page_up  = page_inc(page_cur);
  assign page_use = pick_bnd ? page_up : page_cur;
  assign pick_ofs = pick[0] ? '0 : (pick[1] ? head_mid_ofs : head_end_ofs);
  assign pop      = fire && (after == 3'b000);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sent     <= 3'b000;
    end else if (fire) begin
      m_tvalid <= 1'b1;
      sent     <= (after == 3'b000) ? 3'b000 : (sent | pick);
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ofs  <= OUT_OFS_W'(pick_ofs);
      out_sel  <= pick_bnd && page_in_set(cfg, page_up);
      out_bnd  <= pick_bnd;
      out_end  <= pick[2];
      out_ff   <= pick[2] && head_slots.end_ff;
      out_last <= (after == 3'b000);
      page_run <= page_use;
    end
  end

  assign m_tdata = {(TDATA_W - OUT_OFS_W - 1)'(0), out_sel, out_ofs};
  assign m_tuser = {out_ff, out_end, out_bnd};
  assign m_tlast = out_last;

  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_end |-> out_last)
    else $error("End result is not the last beat of its run.");

  a_sel_needs_bnd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_bnd |-> !out_sel)
    else $error("Page selected on a beat that is no boundary.");

  a_ff_on_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_ff |-> out_end)
    else $error("Formfeed flag on a beat that is not an end result.");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid && sent == (sent & {head_slots.end_v, head_slots.mid_v,
                                           head_slots.start_v}))
    else $error("Queue popped without a matching record at its head.");

endmodule

// ===== hdl/page_boundary_detector.sv =====
// ----------------------------------------------------------------------------
// page_boundary_detector
// Finds page start offsets in a text byte stream, in plain or troff mode.
// ----------------------------------------------------------------------------
// One byte is taken per cycle. Each byte causes zero to three result beats;
// the output sends one beat per cycle while m_tready is high, so a byte that
// causes two or three beats holds the output until all are sent. A queue of
// QUEUE_DEPTH records lets bytes keep arriving while those beats drain, and
// the input stalls only when the queue is full. Each result is registered in
// the queue and again at the output. Configuration writes are taken in any
// cycle and must only be made while no stream results are outstanding.
module page_boundary_detector #(
  parameter int OFFSET_BITS = pbd_pkg::OFFSET_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = pbd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // data_byte
  input  logic                              s_tlast,   // end_of_input
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // bits 31:0 page_offset, bit 32 page_selected, zero above
  output logic [pbd_pkg::TDATA_W-1:0]       m_tdata,
  // bit 0 is_boundary, bit 1 end_result, bit 2 formfeed_appended
  output logic [pbd_pkg::TUSER_W-1:0]       m_tuser,
  output logic                              m_tlast,   // last_of_run
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pbd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pbd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pbd_pkg::*;

  localparam int REC_W = SLOTS_W + 2 * OFFSET_BITS + PAGE_W;

  pbd_cfg_t               cfg;
  logic                   queue_full;
  logic                   push;
  logic                   pop;
  pbd_slots_t             rec_slots;
  logic [OFFSET_BITS-1:0] rec_mid_ofs;
  logic [OFFSET_BITS-1:0] rec_end_ofs;
  logic [PAGE_W-1:0]      rec_page;
  logic                   head_valid;
  logic [REC_W-1:0]       head_data;
  pbd_slots_t             head_slots;
  logic [OFFSET_BITS-1:0] head_mid_ofs;
  logic [OFFSET_BITS-1:0] head_end_ofs;
  logic [PAGE_W-1:0]      head_page;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lines_per_page <= LINES_PER_PAGE_RST;
      cfg.troff_mode     <= 1'b0;
      cfg.end_formfeed   <= 1'b0;
      cfg.select_all     <= 1'b1;
      cfg.range_a_first  <= RANGE_A_FIRST_RST;
      cfg.range_a_last   <= RANGE_A_LAST_RST;
      cfg.range_b_first  <= RANGE_B_FIRST_RST;
      cfg.range_b_last   <= RANGE_B_LAST_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        REG_LINES_PER_PAGE: cfg.lines_per_page <= cfg_data[LINES_W-1:0];
        REG_TROFF_MODE:     cfg.troff_mode     <= cfg_data[0];
        REG_END_FORMFEED:   cfg.end_formfeed   <= cfg_data[0];
        REG_SELECT_ALL:     cfg.select_all     <= cfg_data[0];
        REG_RANGE_A_FIRST:  cfg.range_a_first  <= cfg_data[PAGE_W-1:0];
        REG_RANGE_A_LAST:   cfg.range_a_last   <= cfg_data[PAGE_W-1:0];
        REG_RANGE_B_FIRST:  cfg.range_b_first  <= cfg_data[PAGE_W-1:0];
        REG_RANGE_B_LAST:   cfg.range_b_last   <= cfg_data[PAGE_W-1:0];
        default:            cfg.troff_mode     <= cfg.troff_mode;
      endcase
    end
  end

  pbd_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .queue_full  (queue_full),
    .push        (push),
    .rec_slots   (rec_slots),
    .rec_mid_ofs (rec_mid_ofs),
    .rec_end_ofs (rec_end_ofs),
    .rec_page    (rec_page)
  );

  pbd_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wdata      ({rec_slots, rec_mid_ofs, rec_end_ofs, rec_page}),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign {head_slots, head_mid_ofs, head_end_ofs, head_page} = head_data;

  pbd_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head_slots   (head_slots),
    .head_mid_ofs (head_mid_ofs),
    .head_end_ofs (head_end_ofs),
    .head_page    (head_page),
    .pop          (pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast)
  );

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the page boundary detector. Byte streams are
// driven through the input stream port, and every accepted byte is run
// through a local model of the page logic. Each result beat is compared
// field by field with the oldest predicted beat. Directed plain and troff
// streams come first, then random line-shaped streams under a series of
// register settings. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import pbd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4 * QUEUE_DEPTH_DEFAULT + 8;
  localparam int PHASES        = 8;
  localparam int PHASE_BYTES   = 40;

  typedef struct packed {
    logic [OUT_OFS_W-1:0] offset;
    logic                 selected;
    logic                 boundary;
    logic                 closing;
    logic                 ff_added;
    logic                 run_last;
  } page_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata   = 8'h00;
  logic                   s_tlast   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [TDATA_W-1:0]     m_tdata;
  logic [TUSER_W-1:0]     m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  pbd_cfg_t             cfg_shadow;
  logic [OUT_OFS_W-1:0] byte_cnt;
  logic [OUT_OFS_W-1:0] line_start;
  logic [LINES_W-1:0]   line_cnt;
  logic                 full_flag;
  logic                 started;
  logic [PAGE_W-1:0]    page_num;

  text_byte_t pending_bytes[$];
  page_beat_t page_starts_q[$];
  page_beat_t step_beats[$];
  text_byte_t next_byte;

  int  errors       = 0;
  int  gap_left     = 0;
  int  stall_left   = 0;
  int  bytes_sent   = 0;
  int  bytes_queued = 0;
  int  beats_seen   = 0;
  int  settings     = 0;
  int  cycles       = 0;
  bit  idle_en      = 1'b1;

  page_boundary_detector dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void clear_stream();
    byte_cnt   = '0;
    line_cnt   = '0;
    full_flag  = 1'b0;
    line_start = '0;
    page_num   = '0;
    started    = 1'b0;
  endfunction

  function automatic void bump_bytes();
    if (byte_cnt != '1) byte_cnt = byte_cnt + OUT_OFS_W'(1);
  endfunction

  function automatic logic take_page();
    if (page_num != PAGE_MAX) page_num = page_num + PAGE_W'(1);
    return cfg_shadow.select_all
        || (page_num >= cfg_shadow.range_a_first && page_num <= cfg_shadow.range_a_last)
        || (page_num >= cfg_shadow.range_b_first && page_num <= cfg_shadow.range_b_last);
  endfunction

  function automatic void add_beat(input logic [OUT_OFS_W-1:0] ofs, input logic sel,
                                   input logic bnd, input logic closing, input logic ff);
    page_beat_t b;
    b.offset   = ofs;
    b.selected = sel;
    b.boundary = bnd;
    b.closing  = closing;
    b.ff_added = ff;
    b.run_last = 1'b0;
    step_beats.push_back(b);
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic eoi);
    logic       plain;
    logic       ff;
    logic       bnd;
    logic       sel;
    page_beat_t pb;
    plain = !cfg_shadow.troff_mode;
    step_beats.delete();
    if (!started) begin
      started = 1'b1;
      if (plain) add_beat('0, take_page(), 1'b1, 1'b0, 1'b0);
    end
    if (plain) begin
      if (b == CH_NL) begin
        bump_bytes();
        if (line_cnt != LINES_MAX) line_cnt = line_cnt + LINES_W'(1);
        if (line_cnt >= cfg_shadow.lines_per_page) begin
          add_beat(byte_cnt, take_page(), 1'b1, 1'b0, 1'b0);
          line_cnt  = '0;
          full_flag = 1'b1;
        end
      end else if (b == CH_FF) begin
        bump_bytes();
        if (!full_flag) begin
          add_beat(byte_cnt, take_page(), 1'b1, 1'b0, 1'b0);
          line_cnt = '0;
        end
        full_flag = 1'b0;
      end else begin
        full_flag = 1'b0;
        bump_bytes();
      end
    end else begin
      if (b == CH_NL) begin
        if (line_cnt > TROFF_MARK_LEN) add_beat(line_start, take_page(), 1'b1, 1'b0, 1'b0);
        bump_bytes();
        line_start = byte_cnt;
        line_cnt   = TROFF_LINE_START;
      end else if (b == CH_P) begin
        line_cnt = (line_cnt == TROFF_LINE_START) ? TROFF_MARK_LEN : '0;
        bump_bytes();
      end else if (b >= CH_DIG_0 && b <= CH_DIG_9) begin
        if (line_cnt >= TROFF_MARK_LEN) begin
          if (line_cnt != LINES_MAX) line_cnt = line_cnt + LINES_W'(1);
        end else begin
          line_cnt = '0;
        end
        bump_bytes();
      end else begin
        line_cnt = '0;
        bump_bytes();
      end
    end
    if (eoi) begin
      ff  = plain && cfg_shadow.end_formfeed && (line_cnt != '0);
      bnd = !plain || !full_flag;
      if (ff) bump_bytes();
      sel = bnd ? take_page() : 1'b0;
      add_beat(byte_cnt, sel, bnd, 1'b1, ff);
      clear_stream();
    end
    foreach (step_beats[i]) begin
      pb          = step_beats[i];
      pb.run_last = (i == step_beats.size() - 1);
      page_starts_q.push_back(pb);
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic string beat_str(input page_beat_t b);
    return $sformatf("ofs=%0d sel=%b bnd=%b end=%b ff=%b last=%b",
                     b.offset, b.selected, b.boundary, b.closing, b.ff_added, b.run_last);
  endfunction

  task automatic check_beat();
    page_beat_t want;
    page_beat_t got;
    got.offset   = m_tdata[OUT_OFS_W-1:0];
    got.selected = m_tdata[OUT_OFS_W];
    got.boundary = m_tuser[0];
    got.closing  = m_tuser[1];
    got.ff_added = m_tuser[2];
    got.run_last = m_tlast;
    beats_seen++;
    if (page_starts_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("Unexpected beat: %s", beat_str(got));
    end else begin
      want = page_starts_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("Mismatch: expected %s, got %s", beat_str(want), beat_str(got));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_byte(s_tdata, s_tlast);
        bytes_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          next_byte = pending_bytes.pop_front();
          s_tvalid  <= 1'b1;
          s_tdata   <= next_byte.data;
          s_tlast   <= next_byte.last;
          gap_left  = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_beat();
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready   <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("FAIL page_boundary_detector");
      $finish;
    end
  end

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LINES_PER_PAGE: cfg_shadow.lines_per_page = val[LINES_W-1:0];
      REG_TROFF_MODE:     cfg_shadow.troff_mode     = val[0];
      REG_END_FORMFEED:   cfg_shadow.end_formfeed   = val[0];
      REG_SELECT_ALL:     cfg_shadow.select_all     = val[0];
      REG_RANGE_A_FIRST:  cfg_shadow.range_a_first  = val[PAGE_W-1:0];
      REG_RANGE_A_LAST:   cfg_shadow.range_a_last   = val[PAGE_W-1:0];
      REG_RANGE_B_FIRST:  cfg_shadow.range_b_first  = val[PAGE_W-1:0];
      REG_RANGE_B_LAST:   cfg_shadow.range_b_last   = val[PAGE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [LINES_W-1:0] lpp, input logic troff,
                            input logic end_ff, input logic all_pages,
                            input logic [PAGE_W-1:0] a_first, input logic [PAGE_W-1:0] a_last,
                            input logic [PAGE_W-1:0] b_first, input logic [PAGE_W-1:0] b_last);
    write_reg(REG_LINES_PER_PAGE, CFG_DATA_W'(lpp));
    write_reg(REG_TROFF_MODE, CFG_DATA_W'(troff));
    write_reg(REG_END_FORMFEED, CFG_DATA_W'(end_ff));
    write_reg(REG_SELECT_ALL, CFG_DATA_W'(all_pages));
    write_reg(REG_RANGE_A_FIRST, CFG_DATA_W'(a_first));
    write_reg(REG_RANGE_A_LAST, CFG_DATA_W'(a_last));
    write_reg(REG_RANGE_B_FIRST, CFG_DATA_W'(b_first));
    write_reg(REG_RANGE_B_LAST, CFG_DATA_W'(b_last));
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic last);
    text_byte_t t;
    t.data = b;
    t.last = last;
    pending_bytes.push_back(t);
    bytes_queued++;
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || s_tvalid || page_starts_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic pick_range(output logic [PAGE_W-1:0] first, output logic [PAGE_W-1:0] last);
    case ($urandom_range(0, 4))
      0: begin
        first = PAGE_W'($urandom_range(1, 5));
        last  = first + PAGE_W'($urandom_range(0, 3));
      end
      1: begin
        first = PAGE_W'($urandom_range(2, 8));
        last  = first - PAGE_W'(1);
      end
      2: begin
        first = PAGE_MAX;
        last  = PAGE_MAX;
      end
      3: begin
        first = PAGE_W'(1);
        last  = PAGE_MAX;
      end
      default: begin
        first = PAGE_W'($urandom_range(3, 10));
        last  = '0;
      end
    endcase
  endtask

  task automatic gen_stream(input bit closed);
    logic [7:0] line_q[$];
    int         lines;
    int         n;
    int         r;
    lines = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
    for (int k = 0; k < lines; k++) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        line_q.push_back(CH_P);
        n = $urandom_range(1, 3);
        repeat (n) line_q.push_back(CH_DIG_0 + 8'($urandom_range(0, 9)));
        n = $urandom_range(0, 4);
        repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
      end else if (r == 4) begin
        line_q.push_back(CH_P);
        n = $urandom_range(0, 3);
        repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
      end else if (r == 5) begin
        line_q.push_back(CH_FF);
      end else if (r > 6) begin
        n = $urandom_range(0, 6);
        repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
      end
      if (k < lines - 1 || $urandom_range(0, 1)) line_q.push_back(CH_NL);
    end
    if (line_q.size() == 0) line_q.push_back(8'($urandom_range(0, 255)));
    foreach (line_q[i]) queue_byte(line_q[i], closed && (i == line_q.size() - 1));
  endtask

  initial begin
    logic [PAGE_W-1:0]  af;
    logic [PAGE_W-1:0]  al;
    logic [PAGE_W-1:0]  bf;
    logic [PAGE_W-1:0]  bl;
    logic [LINES_W-1:0] lpp;
    int                 target;

    cfg_shadow.lines_per_page = LINES_PER_PAGE_RST;
    cfg_shadow.troff_mode     = 1'b0;
    cfg_shadow.end_formfeed   = 1'b0;
    cfg_shadow.select_all     = 1'b1;
    cfg_shadow.range_a_first  = RANGE_A_FIRST_RST;
    cfg_shadow.range_a_last   = RANGE_A_LAST_RST;
    cfg_shadow.range_b_first  = RANGE_B_FIRST_RST;
    cfg_shadow.range_b_last   = RANGE_B_LAST_RST;
    clear_stream();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    queue_byte(8'h61, 1'b0);
    queue_byte(CH_NL, 1'b0);
    queue_byte(8'h62, 1'b1);
    drain();

    set_config(LINES_W'(2), 1'b0, 1'b1, 1'b0, PAGE_W'(1), PAGE_W'(2), PAGE_W'(4), PAGE_MAX);
    // A formfeed straight after a page-filling newline opens no new page.
    queue_byte(8'h61, 1'b0);
    queue_byte(CH_NL, 1'b0);
    queue_byte(CH_NL, 1'b0);
    queue_byte(CH_FF, 1'b0);
    queue_byte(8'h78, 1'b0);
    queue_byte(CH_FF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(CH_NL, 1'b1);
    queue_byte(8'h5A, 1'b1);
    queue_byte(CH_NL, 1'b0);
    queue_byte(CH_NL, 1'b1);
    queue_byte(CH_FF, 1'b0);
    queue_byte(8'h62, 1'b1);
    drain();

    write_reg(REG_TROFF_MODE, CFG_DATA_W'(1));
    cfg_valid <= 1'b0;
    queue_byte(CH_P, 1'b0);
    queue_byte(8'h31, 1'b0);
    queue_byte(CH_NL, 1'b0);
    queue_byte(CH_P, 1'b0);
    queue_byte(8'h39, 1'b0);
    queue_byte(8'h39, 1'b0);
    queue_byte(CH_NL, 1'b0);
    queue_byte(CH_P, 1'b0);
    queue_byte(CH_NL, 1'b0);
    queue_byte(8'h31, 1'b0);
    queue_byte(CH_P, 1'b0);
    queue_byte(8'h35, 1'b0);
    queue_byte(CH_NL, 1'b0);
    queue_byte(CH_P, 1'b0);
    queue_byte(8'h30, 1'b1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      pick_range(af, al);
      pick_range(bf, bl);
      if (p == 0) lpp = LINES_W'(1);
      else if (p == 6) lpp = LINES_MAX;
      else lpp = LINES_W'($urandom_range(2, 6));
      set_config(lpp, (p % 3) == 1, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                 af, al, bf, bl);
      idle_en = (p % 3) != 2;
      target  = bytes_queued + PHASE_BYTES;
      while (bytes_queued < target) gen_stream($urandom_range(0, 9) != 0);
      drain();
    end

    $display("Sent %0d bytes and checked %0d result beats under %0d register settings,",
             bytes_sent, beats_seen, settings);
    $display("in plain and troff mode with random idling on both streams.");
    if (errors == 0 && page_starts_q.size() == 0) begin
      $display("PASS page_boundary_detector");
    end else begin
      $display("%0d mismatches, %0d beats still expected.", errors, page_starts_q.size());
      $display("FAIL page_boundary_detector");
    end
    $finish;
  end

endmodule
